### rtl/ilss_pkg.sv
// Shared command codes, status codes and controller/datapath interface types.
`default_nettype none

package ilss_pkg;

	// Input item command codes
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_CLEAN  = 3'd2;
	localparam logic [2:0] CMD_SORT   = 3'd3;
	localparam logic [2:0] CMD_LIST   = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Fixed field widths
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CNT_W = 6;

	// Commands from controller to datapath
	typedef struct packed {
		logic       ld_op;     // capture operand
		logic       ptr_rst;   // clear read and write pointers
		logic       rd_en;     // read entry at read pointer, advance
		logic       wr_add;    // append operand at tail
		logic       clr_cnt;   // empty the list
		logic       rem_step;  // keep read entry if it differs from operand
		logic       rem_fin;   // commit compacted count
		logic       srt_load;  // first entry of a pass into carry
		logic       srt_step;  // write smaller, carry larger
		logic       srt_fin;   // write carry at end of pass
		logic       pass_rst;  // first sort pass
		logic       pass_inc;  // next sort pass
		logic       emit;      // load output registers
		logic       emit_elem; // output carries a listed entry
		logic [1:0] emit_st;   // status of the emitted result
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
		logic cnt_full;
		logic rd_more;   // read pointer below fill count
		logic ridx_zero; // entry just read is the head
		logic ridx_last; // entry just read is the tail
		logic last_pass; // current sort pass is the final one
	} stat_t;

endpackage

`default_nettype wire

### rtl/ilss_dpath.sv
// Datapath: entry memory, fill count, pointers, compare/swap carry and output registers.
`default_nettype none

module ilss_dpath import ilss_pkg::*; #(
	parameter int unsigned DEPTH = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  ctl_t                      ctl,
	output stat_t                     stat,
	input  wire  signed [VAL_W-1:0]   operand_value,
	output logic                      strobe,
	output logic signed [VAL_W-1:0]   element_value,
	output logic                      last_result,
	output logic [1:0]                status,
	output logic [CNT_W-1:0]          entry_count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic signed [VAL_W-1:0] mem [DEPTH];

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           rd_q;
	logic [CW-1:0]           wr_q;
	logic [CW-1:0]           pass_q;
	logic signed [VAL_W-1:0] op_q;
	logic signed [VAL_W-1:0] carry_q;
	logic signed [VAL_W-1:0] rdata_s1;
	logic [CW-1:0]           ridx_s1;

	logic                    keep;
	logic                    gt;
	logic signed [VAL_W-1:0] lo;
	logic signed [VAL_W-1:0] hi;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic signed [VAL_W-1:0] wdata;
	logic [CW-1:0]           count_m1;

	// Compare and swap
	assign keep     = (rdata_s1 != op_q);
	assign gt       = (carry_q > rdata_s1);
	assign lo       = gt ? rdata_s1 : carry_q;
	assign hi       = gt ? carry_q : rdata_s1;
	assign count_m1 = count_q - CW'(1);

	// Status towards the controller
	assign stat.cnt_zero  = (count_q == '0);
	assign stat.cnt_one   = (count_q == CW'(1));
	assign stat.cnt_full  = (count_q == CW'(DEPTH));
	assign stat.rd_more   = (rd_q < count_q);
	assign stat.ridx_zero = (ridx_s1 == '0);
	assign stat.ridx_last = (ridx_s1 == count_m1);
	assign stat.last_pass = (pass_q == count_m1);

	// Write port select
	always_comb begin
		we    = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = rdata_s1;
		if (ctl.wr_add) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = operand_value;
		end else if (ctl.rem_step) begin
			we    = keep;
		end else if (ctl.srt_step) begin
			we    = 1'b1;
			wdata = lo;
		end else if (ctl.srt_fin) begin
			we    = 1'b1;
			wdata = carry_q;
		end
	end

	// Entry memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_s1 <= mem[rd_q[AW-1:0]];
			ridx_s1  <= rd_q;
		end
	end

	// Operand and carry
	always_ff @(posedge clk) begin
		if (ctl.ld_op) begin
			op_q <= operand_value;
		end
		if (ctl.srt_load) begin
			carry_q <= rdata_s1;
		end else if (ctl.srt_step) begin
			carry_q <= hi;
		end
	end

	// Count, pointers and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			pass_q  <= '0;
		end else begin
			if (ctl.wr_add) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.clr_cnt) begin
				count_q <= '0;
			end else if (ctl.rem_fin) begin
				count_q <= wr_q + CW'(keep);
			end

			if (ctl.ptr_rst) begin
				rd_q <= '0;
			end else if (ctl.rd_en) begin
				rd_q <= rd_q + CW'(1);
			end

			if (ctl.ptr_rst) begin
				wr_q <= '0;
			end else if ((ctl.rem_step && keep) || ctl.srt_step) begin
				wr_q <= wr_q + CW'(1);
			end

			if (ctl.pass_rst) begin
				pass_q <= CW'(1);
			end else if (ctl.pass_inc) begin
				pass_q <= pass_q + CW'(1);
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= ctl.emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			element_value <= ctl.emit_elem ? rdata_s1 : '0;
			last_result   <= ctl.emit_elem ? stat.ridx_last : 1'b1;
			status        <= ctl.emit_st;
			entry_count   <= CNT_W'(count_q);
		end
	end

endmodule

`default_nettype wire

### rtl/ilss_ctrl.sv
// Controller: command decode and sequencing of add, remove, cleanup, sort and list.
`default_nettype none

module ilss_ctrl import ilss_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire  [2:0] command,
	output logic       busy,
	input  stat_t      stat,
	output ctl_t       ctl
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_REM  = 3'd1;
	localparam logic [2:0] S_SRT  = 3'd2;
	localparam logic [2:0] S_SRTE = 3'd3;
	localparam logic [2:0] S_LST  = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] st_q;
	logic [1:0] st_d;
	logic       rv_s1;

	assign busy = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (command)
						CMD_ADD: begin
							ctl.wr_add = !stat.cnt_full;
							st_d       = stat.cnt_full ? ST_FULL : ST_OK;
							state_d    = S_RESP;
						end
						CMD_REMOVE: begin
							ctl.ld_op   = 1'b1;
							ctl.ptr_rst = 1'b1;
							st_d        = stat.cnt_zero ? ST_EMPTY : ST_OK;
							state_d     = stat.cnt_zero ? S_RESP : S_REM;
						end
						CMD_CLEAN: begin
							ctl.clr_cnt = 1'b1;
							st_d        = stat.cnt_zero ? ST_EMPTY : ST_OK;
							state_d     = S_RESP;
						end
						CMD_SORT: begin
							ctl.ptr_rst  = 1'b1;
							ctl.pass_rst = 1'b1;
							st_d         = stat.cnt_zero ? ST_EMPTY : ST_OK;
							state_d      = (stat.cnt_zero || stat.cnt_one) ? S_RESP : S_SRT;
						end
						CMD_LIST: begin
							ctl.ptr_rst = 1'b1;
							st_d        = ST_EMPTY;
							state_d     = stat.cnt_zero ? S_RESP : S_LST;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			// Stream compaction: surviving entries rewritten at the write pointer
			S_REM: begin
				ctl.rd_en = stat.rd_more;
				if (rv_s1) begin
					ctl.rem_step = 1'b1;
					if (stat.ridx_last) begin
						ctl.rem_fin = 1'b1;
						state_d     = S_RESP;
					end
				end
			end
			// One bubble pass: larger value carried towards the tail
			S_SRT: begin
				ctl.rd_en = stat.rd_more;
				if (rv_s1) begin
					ctl.srt_load = stat.ridx_zero;
					ctl.srt_step = !stat.ridx_zero;
					if (stat.ridx_last) begin
						state_d = S_SRTE;
					end
				end
			end
			S_SRTE: begin
				ctl.srt_fin = 1'b1;
				if (stat.last_pass) begin
					state_d = S_RESP;
				end else begin
					ctl.ptr_rst  = 1'b1;
					ctl.pass_inc = 1'b1;
					state_d      = S_SRT;
				end
			end
			S_LST: begin
				ctl.rd_en = stat.rd_more;
				if (rv_s1) begin
					ctl.emit      = 1'b1;
					ctl.emit_elem = 1'b1;
					ctl.emit_st   = ST_OK;
					if (stat.ridx_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_RESP: begin
				ctl.emit    = 1'b1;
				ctl.emit_st = st_q;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, pending status and read-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			rv_s1   <= ctl.rd_en;
		end
	end

endmodule

`default_nettype wire

### rtl/integer_list_store_with_sort_core.sv
// Top level: bounded ordered integer list with add, remove, cleanup, sort and list commands.
// List streams one element per cycle; each walk reads entries through the registered memory
// read; sort is n-1 bubble passes (n = entries held). A new item is taken in the cycle that
// the final result is strobed; results cannot stall.
// Asynchronous active-low reset empties the list; entry contents are not cleared.
`default_nettype none

module integer_list_store_with_sort_core import ilss_pkg::*; #(
	parameter int unsigned DEPTH = 32
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire  [2:0]               command,
	input  wire  signed [VAL_W-1:0]  operand_value,
	output logic                     strobe,
	output logic signed [VAL_W-1:0]  element_value,
	output logic                     last_result,
	output logic [1:0]               status,
	output logic [CNT_W-1:0]         entry_count
);

	ctl_t  ctl;
	stat_t stat;

	ilss_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.busy    (busy),
		.stat    (stat),
		.ctl     (ctl)
	);

	ilss_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.operand_value (operand_value),
		.strobe        (strobe),
		.element_value (element_value),
		.last_result   (last_result),
		.status        (status),
		.entry_count   (entry_count)
	);

`ifndef NO_ASSERTIONS
	// Never append into a full store
	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_add |-> !stat.cnt_full)
		else $error("append issued with store full");

	// Reads stay below the fill count
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |-> stat.rd_more)
		else $error("read beyond fill count");

	// Swap step never on the head entry of a pass
	a_srt_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.srt_step |-> !stat.ridx_zero)
		else $error("sort step on head entry");

	// Non-ok results always close their command
	a_st_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != ST_OK) |-> last_result)
		else $error("error status without last mark");
`endif

endmodule

`default_nettype wire
